/* design/one_wire_bus_master_top_assert.svh */
// Assertion macros for the one-wire bus master checker.
// Used by owbm_checker.sv; needs a clock i_clk and a reset i_rst_n in scope.
`ifndef ONE_WIRE_BUS_MASTER_TOP_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OWBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OWBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/owbm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the one-wire bus master.
// No dependencies; used by the top level and its checker.
package owbm_pkg;

    localparam int TIME_W = 10;
    localparam int BYTE_W = 8;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_WATCH = 4'd3,
        PH_W_LOW     = 4'd4,
        PH_W_REC     = 4'd5,
        PH_R_LOW     = 4'd6,
        PH_R_WAIT    = 4'd7,
        PH_R_REC     = 4'd8
    } t_phase;

    // Command codes; the fourth code is ignored.
    localparam logic [1:0] CMD_RESET = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RESET_LOW   = 3'd0;
    localparam logic [2:0] CFG_PRES_DELAY  = 3'd1;
    localparam logic [2:0] CFG_PRES_WINDOW = 3'd2;
    localparam logic [2:0] CFG_SHORT_LOW   = 3'd3;
    localparam logic [2:0] CFG_ZERO_LOW    = 3'd4;
    localparam logic [2:0] CFG_SAMPLE_DLY  = 3'd5;
    localparam logic [2:0] CFG_ONE_REC     = 3'd6;
    localparam logic [2:0] CFG_READ_REC    = 3'd7;

    localparam logic [TIME_W-1:0] RST_RESET_LOW   = 10'd500;
    localparam logic [TIME_W-1:0] RST_PRES_DELAY  = 10'd60;
    localparam logic [TIME_W-1:0] RST_PRES_WINDOW = 10'd300;
    localparam logic [TIME_W-1:0] RST_SHORT_LOW   = 10'd6;
    localparam logic [TIME_W-1:0] RST_ZERO_LOW    = 10'd70;
    localparam logic [TIME_W-1:0] RST_SAMPLE_DLY  = 10'd9;
    localparam logic [TIME_W-1:0] RST_ONE_REC     = 10'd60;
    localparam logic [TIME_W-1:0] RST_READ_REC    = 10'd55;

    // Result tdata layout.
    localparam int OUT_DRIVE    = 0;
    localparam int OUT_BUSY     = 1;
    localparam int OUT_DONE     = 2;
    localparam int OUT_RDATA_LO = 3;
    localparam int OUT_PRESENCE = 11;

endpackage

/* design/one_wire_bus_master_top.sv */
`timescale 1ns / 1ps
// One-wire bus master: command sequencer, timing counter and result buffer.
// Depends on owbm_pkg.
//
// Usage: each input transaction on the s_axis channel is either a microsecond
// tick (tuser = 0) carrying the sampled line level, or a start command
// (tuser = 1) carrying the command code and, for a write, the byte to send.
// Commands are reset with presence detect, byte write and byte read, bits
// least significant first. Every input transaction gives exactly one result
// transaction on m_axis with the drive level, busy, done, last read byte and
// presence flag as they stand after that item.
// Results are registered; one item is taken every cycle while s_axis_tready
// is high. The whole update of the phase, counter and shift register is done
// in the cycle of acceptance, so the state loop sets the one-item-per-cycle
// rate. A two-entry output buffer lets input continue while a result waits;
// when both entries are full s_axis_tready drops until the receiver takes one.
// Configuration writes go through i_cfg_we / i_cfg_idx / i_cfg_data and take
// effect at once; they are meant for idle periods.
// Reset restores the default timings, returns to idle with presence and read
// data cleared, and empties the output buffer.
module one_wire_bus_master_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] command, [9:2] write_byte, [10] line_level, [15:11] zero
    input  logic [owbm_pkg::IN_W-1:0]     s_axis_tdata,
    // [0] req_type
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_data,
    // [11] presence, [15:12] zero
    output logic [owbm_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [owbm_pkg::TIME_W-1:0]   i_cfg_data
);
    import owbm_pkg::*;

    // Configuration registers.
    logic [TIME_W-1:0] r_reset_low, r_pres_delay, r_pres_window, r_short_low;
    logic [TIME_W-1:0] r_zero_low, r_sample_dly, r_one_rec, r_read_rec;

    // Sequencer state.
    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_time_count, n_time_count;
    logic [2:0]        r_bit_index, n_bit_index;
    logic [BYTE_W-1:0] r_shift_byte, n_shift_byte;
    logic              r_seen_low, n_seen_low;
    logic              r_presence, n_presence;
    logic [1:0]        r_active_cmd, n_active_cmd;
    logic [BYTE_W-1:0] r_read_data, n_read_data;
    logic              n_done;

    // Output buffer.
    logic              r_out_valid, r_skid_valid;
    logic [OUT_W-1:0]  r_out_data, r_skid_data;
    logic [OUT_W-1:0]  n_result;

    logic              in_accept, out_accept;
    logic              in_req;
    logic [1:0]        in_cmd;
    logic [BYTE_W-1:0] in_wbyte;
    logic              in_line;

    assign in_req   = s_axis_tuser;
    assign in_cmd   = s_axis_tdata[1:0];
    assign in_wbyte = s_axis_tdata[9:2];
    assign in_line  = s_axis_tdata[10];

    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low   <= RST_RESET_LOW;
            r_pres_delay  <= RST_PRES_DELAY;
            r_pres_window <= RST_PRES_WINDOW;
            r_short_low   <= RST_SHORT_LOW;
            r_zero_low    <= RST_ZERO_LOW;
            r_sample_dly  <= RST_SAMPLE_DLY;
            r_one_rec     <= RST_ONE_REC;
            r_read_rec    <= RST_READ_REC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RESET_LOW:   r_reset_low   <= i_cfg_data;
                CFG_PRES_DELAY:  r_pres_delay  <= i_cfg_data;
                CFG_PRES_WINDOW: r_pres_window <= i_cfg_data;
                CFG_SHORT_LOW:   r_short_low   <= i_cfg_data;
                CFG_ZERO_LOW:    r_zero_low    <= i_cfg_data;
                CFG_SAMPLE_DLY:  r_sample_dly  <= i_cfg_data;
                CFG_ONE_REC:     r_one_rec     <= i_cfg_data;
                CFG_READ_REC:    r_read_rec    <= i_cfg_data;
                default:         r_read_rec    <= r_read_rec;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_time_count <= '0;
            r_bit_index  <= '0;
            r_shift_byte <= '0;
            r_seen_low   <= 1'b0;
            r_presence   <= 1'b0;
            r_active_cmd <= CMD_RESET;
            r_read_data  <= '0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_time_count <= n_time_count;
            r_bit_index  <= n_bit_index;
            r_shift_byte <= n_shift_byte;
            r_seen_low   <= n_seen_low;
            r_presence   <= n_presence;
            r_active_cmd <= n_active_cmd;
            r_read_data  <= n_read_data;
        end
    end

    always_comb begin
        logic [TIME_W-1:0] len_raw;
        logic              len_min_one;
        logic [TIME_W-1:0] len;
        logic [TIME_W-1:0] tc_inc;
        logic              bit_done;
        logic [BYTE_W-1:0] bd_shift;
        logic [2:0]        bit_inc;

        n_phase      = r_phase;
        n_time_count = r_time_count;
        n_bit_index  = r_bit_index;
        n_shift_byte = r_shift_byte;
        n_seen_low   = r_seen_low;
        n_presence   = r_presence;
        n_active_cmd = r_active_cmd;
        n_read_data  = r_read_data;
        n_done       = 1'b0;
        bit_done     = 1'b0;
        bd_shift     = r_shift_byte;
        bit_inc      = r_bit_index + 3'd1;
        tc_inc       = r_time_count + 10'd1;

        // Length of the current phase; recovery phases may be zero.
        len_min_one = 1'b1;
        unique case (r_phase)
            PH_RST_LOW:   len_raw = r_reset_low;
            PH_RST_WAIT:  len_raw = r_pres_delay;
            PH_RST_WATCH: len_raw = r_pres_window;
            PH_W_LOW:     len_raw = r_shift_byte[0] ? r_short_low : r_zero_low;
            PH_W_REC: begin
                len_raw     = r_one_rec;
                len_min_one = 1'b0;
            end
            PH_R_LOW:     len_raw = r_short_low;
            PH_R_WAIT:    len_raw = r_sample_dly;
            PH_R_REC: begin
                len_raw     = r_read_rec;
                len_min_one = 1'b0;
            end
            default:      len_raw = 10'd1;
        endcase
        len = (len_min_one && len_raw == '0) ? 10'd1 : len_raw;

        if (in_req) begin
            if (r_phase == PH_IDLE && in_cmd != CMD_NONE) begin
                n_active_cmd = in_cmd;
                n_bit_index  = '0;
                n_time_count = '0;
                if (in_cmd == CMD_RESET) begin
                    n_seen_low = 1'b0;
                    n_phase    = PH_RST_LOW;
                end else if (in_cmd == CMD_WRITE) begin
                    n_shift_byte = in_wbyte;
                    n_phase      = PH_W_LOW;
                end else begin
                    n_shift_byte = '0;
                    n_phase      = PH_R_LOW;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            if (r_phase == PH_RST_WATCH && !in_line) begin
                n_seen_low = 1'b1;
            end
            n_time_count = tc_inc;
            if (tc_inc >= len) begin
                n_time_count = '0;
                unique case (r_phase)
                    PH_RST_LOW:  n_phase = PH_RST_WAIT;
                    PH_RST_WAIT: n_phase = PH_RST_WATCH;
                    PH_RST_WATCH: begin
                        // The presence flag includes this tick's sample.
                        n_presence = n_seen_low;
                        n_phase    = PH_IDLE;
                        n_done     = 1'b1;
                    end
                    PH_W_LOW: begin
                        if (r_shift_byte[0] && r_one_rec != '0) begin
                            n_phase = PH_W_REC;
                        end else begin
                            bit_done = 1'b1;
                        end
                    end
                    PH_W_REC:    bit_done = 1'b1;
                    PH_R_LOW:    n_phase = PH_R_WAIT;
                    PH_R_WAIT: begin
                        bd_shift     = {in_line, r_shift_byte[BYTE_W-1:1]};
                        n_shift_byte = bd_shift;
                        if (r_read_rec != '0) begin
                            n_phase = PH_R_REC;
                        end else begin
                            bit_done = 1'b1;
                        end
                    end
                    PH_R_REC:    bit_done = 1'b1;
                    default:     n_phase = PH_IDLE;
                endcase
            end
        end

        if (bit_done) begin
            if (r_active_cmd == CMD_WRITE) begin
                bd_shift = {1'b0, bd_shift[BYTE_W-1:1]};
            end
            n_shift_byte = bd_shift;
            n_bit_index  = bit_inc;
            if (bit_inc == '0) begin
                if (r_active_cmd == CMD_READ) begin
                    n_read_data = bd_shift;
                end
                n_phase = PH_IDLE;
                n_done  = 1'b1;
            end else begin
                n_phase = (r_active_cmd == CMD_WRITE) ? PH_W_LOW : PH_R_LOW;
            end
        end
    end

    always_comb begin
        n_result = '0;
        n_result[OUT_DRIVE] = (n_phase == PH_RST_LOW) || (n_phase == PH_W_LOW)
                              || (n_phase == PH_R_LOW);
        n_result[OUT_BUSY]  = (n_phase != PH_IDLE);
        n_result[OUT_DONE]  = n_done;
        n_result[OUT_RDATA_LO +: BYTE_W] = n_read_data;
        n_result[OUT_PRESENCE] = n_presence;
    end

    // Two-entry output buffer: the skid entry fills only while the output
    // entry is held by the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_accept) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_accept) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_accept) begin
                r_out_data <= n_result;
            end
        end else if (in_accept) begin
            if (!r_out_valid) begin
                r_out_data <= n_result;
            end else begin
                r_skid_data <= n_result;
            end
        end
    end

endmodule

/* design/owbm_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the one-wire bus master, bound to the top level.
// Depends on owbm_pkg and one_wire_bus_master_top_assert.svh.
`include "one_wire_bus_master_top_assert.svh"

module owbm_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [owbm_pkg::OUT_W-1:0]  m_axis_tdata
);
    import owbm_pkg::*;

    logic out_drive, out_busy, out_done;

    assign out_drive = m_axis_tdata[OUT_DRIVE];
    assign out_busy  = m_axis_tdata[OUT_BUSY];
    assign out_done  = m_axis_tdata[OUT_DONE];

    `OWBM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Input back-pressure only appears while a result is waiting.
    `OWBM_ASSERT_NOW(a_ready_needs_backlog, !s_axis_tready, m_axis_tvalid,
        "input stalled with no pending result")

    `OWBM_ASSERT_NOW(a_drive_when_busy, m_axis_tvalid && out_drive, out_busy,
        "line driven low while not busy")

    `OWBM_ASSERT_NOW(a_done_is_idle, m_axis_tvalid && out_done, !out_busy && !out_drive,
        "done reported while still busy")

endmodule

bind one_wire_bus_master_top owbm_checker u_owbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
